>>> sv/lih_pkg.sv
// ----------------------------------------------------------------------------
// lih_pkg
// Shared types and codes for the lid interlock with hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

package lih_pkg;

    localparam int unsigned MV_W      = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_EN   = 2'd2;

    localparam logic [MV_W-1:0] OPEN_THR_RST  = 16'd2000;
    localparam logic [MV_W-1:0] CLOSE_THR_RST = 16'd1000;
    localparam logic            PROT_EN_RST   = 1'b1;

    localparam logic KIND_INIT    = 1'b0;
    localparam logic KIND_PROCESS = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [MV_W-1:0] sample_mv;
        logic            exposure_running;
    } t_in_word;

    typedef struct packed {
        logic lid_is_open;
        logic pause_exposure;
        logic resume_exposure;
        logic buzzer_start;
        logic buzzer_halt;
        logic sleep_allowed;
    } t_out_word;

    typedef struct packed {
        logic [MV_W-1:0] open_lvl;
        logic [MV_W-1:0] close_lvl;
        logic            prot_en;
    } t_cfg;

    typedef struct packed {
        logic lid_state;
        logic paused_flag;
    } t_lid_state;

endpackage

`default_nettype wire

>>> sv/lih_if.sv
// ----------------------------------------------------------------------------
// lih_if
// Valid/ready channels carrying sample words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lih_in_if;
    logic              valid;
    logic              ready;
    lih_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lih_out_if;
    logic               valid;
    logic               ready;
    lih_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/lid_interlock_hysteresis.sv
// ----------------------------------------------------------------------------
// lid_interlock_hysteresis
// Open-lid interlock: two-threshold hysteresis on the lid sensor sample with
// pause/resume and buzzer pulses.
// Pipeline: input register, then result register where the lid state and
// paused flag are updated; the result is valid from the result register.
// Throughput: 1 word per cycle unless m_out.ready stalls; the state update sets this.
// Reset: clears both stages, lid state (closed), paused flag and reloads the
// default thresholds and protection enable.
// ----------------------------------------------------------------------------
`default_nettype none

module lid_interlock_hysteresis (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [lih_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [lih_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    lih_in_if.sink                             s_in,
    lih_out_if.source                          m_out
);

    lih_pkg::t_cfg       r_cfg;
    lih_pkg::t_lid_state r_state;
    lih_pkg::t_lid_state n_state;
    lih_pkg::t_in_word   r_s1_word;
    logic                r_s1_vld;
    lih_pkg::t_out_word  r_out_word;
    lih_pkg::t_out_word  n_out_word;
    logic                r_out_vld;
    logic                advance;

    assign advance     = !r_out_vld || m_out.ready;
    assign s_in.ready  = !r_s1_vld || advance;
    assign m_out.valid = r_out_vld;
    assign m_out.data  = r_out_word;

    lih_core u_core (
        .i_word  (r_s1_word),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_word  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_lvl  <= lih_pkg::OPEN_THR_RST;
            r_cfg.close_lvl <= lih_pkg::CLOSE_THR_RST;
            r_cfg.prot_en   <= lih_pkg::PROT_EN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lih_pkg::CFG_OPEN_THR:  r_cfg.open_lvl  <= i_cfg_data;
                lih_pkg::CFG_CLOSE_THR: r_cfg.close_lvl <= i_cfg_data;
                lih_pkg::CFG_PROT_EN:   r_cfg.prot_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_in.ready) begin
            r_s1_vld <= s_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_s1_word <= s_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else if (advance) begin
            r_out_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_vld) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire

>>> sv/lih_core.sv
// ----------------------------------------------------------------------------
// lih_core
// Hysteresis decision and interlock pulse generation for one sample word.
// ----------------------------------------------------------------------------
`default_nettype none

module lih_core (
    input  wire lih_pkg::t_in_word   i_word,
    input  wire lih_pkg::t_cfg       i_cfg,
    input  wire lih_pkg::t_lid_state i_state,
    output lih_pkg::t_lid_state      o_state,
    output lih_pkg::t_out_word       o_word
);

    logic mv_ge_open;
    logic mv_le_open;
    logic mv_le_close;
    logic mv_ge_close;
    logic thr_normal;
    logic thr_invert;
    logic lid_init;
    logic lid_prot;
    logic lid_plain;

    function automatic logic resolve(input logic normal, input logic invert,
                                     input logic ge_op, input logic le_op,
                                     input logic le_cl, input logic ge_cl,
                                     input logic held);
        logic r;
        if (normal) begin
            r = ge_op ? 1'b1 : (le_cl ? 1'b0 : held);
        end else if (invert) begin
            r = le_op ? 1'b1 : (ge_cl ? 1'b0 : held);
        end else begin
            r = ge_op;
        end
        return r;
    endfunction

    assign mv_ge_open  = (i_word.sample_mv >= i_cfg.open_lvl);
    assign mv_le_open  = (i_word.sample_mv <= i_cfg.open_lvl);
    assign mv_le_close = (i_word.sample_mv <= i_cfg.close_lvl);
    assign mv_ge_close = (i_word.sample_mv >= i_cfg.close_lvl);
    assign thr_normal  = (i_cfg.open_lvl > i_cfg.close_lvl);
    assign thr_invert  = (i_cfg.open_lvl < i_cfg.close_lvl);

    assign lid_init  = resolve(thr_normal, thr_invert, mv_ge_open, mv_le_open,
                               mv_le_close, mv_ge_close, 1'b0);
    assign lid_prot  = resolve(thr_normal, thr_invert, mv_ge_open, mv_le_open,
                               mv_le_close, mv_ge_close, i_state.lid_state);
    assign lid_plain = mv_ge_open ? 1'b1 : (mv_le_close ? 1'b0 : i_state.lid_state);

    always_comb begin
        o_state = i_state;
        o_word  = '0;
        if (i_word.kind == lih_pkg::KIND_INIT) begin
            o_state.lid_state   = lid_init;
            o_state.paused_flag = 1'b0;
        end else if (!i_cfg.prot_en) begin
            if (i_state.paused_flag) begin
                o_word.resume_exposure = 1'b1;
                o_word.buzzer_halt     = 1'b1;
                o_state.paused_flag    = 1'b0;
            end
            o_state.lid_state = lid_plain;
        end else begin
            o_state.lid_state = lid_prot;
            if (lid_prot != i_state.lid_state) begin
                if (lid_prot) begin
                    o_word.pause_exposure = i_word.exposure_running;
                    o_state.paused_flag   = i_word.exposure_running;
                    o_word.buzzer_start   = 1'b1;
                end else begin
                    if (i_state.paused_flag) begin
                        o_word.resume_exposure = 1'b1;
                        o_state.paused_flag    = 1'b0;
                    end
                    o_word.buzzer_halt = 1'b1;
                end
            end
        end
        o_word.lid_is_open   = o_state.lid_state;
        o_word.sleep_allowed = !i_word.exposure_running && !o_state.lid_state;
    end

endmodule

`default_nettype wire

>>> test/lid_interlock_hysteresis_chk.sv
// ----------------------------------------------------------------------------
// lid_interlock_hysteresis_chk
// Watches the sample and result channels and the register write port of the
// lid interlock. Keeps its own copy of the thresholds, protection enable,
// lid state and paused flag, predicts one result word per accepted sample
// word and compares each accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module lid_interlock_hysteresis_chk
    import lih_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DAT_W-1:0]  i_cfg_data,
    lih_in_if                    in_ch,
    lih_out_if                   out_ch,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg       cfg_cur;
    t_lid_state lid_st;
    t_out_word  lid_result_q[$];
    t_out_word  want_w;
    int         fails;

    function automatic logic hyst_resolve(input logic [MV_W-1:0] mv,
                                          input logic [MV_W-1:0] op,
                                          input logic [MV_W-1:0] cl,
                                          input logic held);
        if (op > cl) begin
            if (mv >= op) return 1'b1;
            if (mv <= cl) return 1'b0;
            return held;
        end
        if (op < cl) begin
            if (mv <= op) return 1'b1;
            if (mv >= cl) return 1'b0;
            return held;
        end
        return (mv >= op);
    endfunction

    function automatic t_out_word interlock_next(input t_in_word w);
        t_out_word r;
        logic      prev;
        r = '0;
        if (w.kind == KIND_INIT) begin
            lid_st.lid_state   = hyst_resolve(w.sample_mv, cfg_cur.open_lvl,
                                              cfg_cur.close_lvl, 1'b0);
            lid_st.paused_flag = 1'b0;
        end else if (!cfg_cur.prot_en) begin
            if (lid_st.paused_flag) begin
                r.resume_exposure  = 1'b1;
                r.buzzer_halt      = 1'b1;
                lid_st.paused_flag = 1'b0;
            end
            if (w.sample_mv >= cfg_cur.open_lvl) begin
                lid_st.lid_state = 1'b1;
            end else if (w.sample_mv <= cfg_cur.close_lvl) begin
                lid_st.lid_state = 1'b0;
            end
        end else begin
            prev = lid_st.lid_state;
            lid_st.lid_state = hyst_resolve(w.sample_mv, cfg_cur.open_lvl,
                                            cfg_cur.close_lvl, prev);
            if (lid_st.lid_state != prev) begin
                if (lid_st.lid_state) begin
                    if (w.exposure_running) begin
                        r.pause_exposure   = 1'b1;
                        lid_st.paused_flag = 1'b1;
                    end else begin
                        lid_st.paused_flag = 1'b0;
                    end
                    r.buzzer_start = 1'b1;
                end else begin
                    if (lid_st.paused_flag) begin
                        r.resume_exposure  = 1'b1;
                        lid_st.paused_flag = 1'b0;
                    end
                    r.buzzer_halt = 1'b1;
                end
            end
        end
        r.lid_is_open   = lid_st.lid_state;
        r.sleep_allowed = !w.exposure_running && !lid_st.lid_state;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_cur.open_lvl  = OPEN_THR_RST;
            cfg_cur.close_lvl = CLOSE_THR_RST;
            cfg_cur.prot_en   = PROT_EN_RST;
            lid_st            = '0;
            lid_result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OPEN_THR:  cfg_cur.open_lvl  = i_cfg_data[MV_W-1:0];
                    CFG_CLOSE_THR: cfg_cur.close_lvl = i_cfg_data[MV_W-1:0];
                    CFG_PROT_EN:   cfg_cur.prot_en   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (lid_result_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected result word %b", $realtime,
                                 out_ch.data);
                    end
                end else begin
                    want_w = lid_result_q.pop_front();
                    if (out_ch.data !== want_w) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"%0t: result mismatch (open pause resume ",
                                      "bstart bstop sleep) expected %b actual %b"},
                                     $realtime, want_w, out_ch.data);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                lid_result_q.push_back(interlock_next(in_ch.data));
            end
        end
        o_pending    <= lid_result_q.size();
        o_fail_count <= fails;
    end

    initial begin
        fails = 0;
    end

endmodule

>>> test/lid_interlock_hysteresis_tb.sv
// ----------------------------------------------------------------------------
// lid_interlock_hysteresis_tb
// Drives sample words and register writes into the lid interlock with random
// gaps and result back-pressure, including one long receiver hold-off, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module lid_interlock_hysteresis_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lih_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 160;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    int                   fail_count;
    int                   pending;
    logic                 tx_idle;
    logic                 rx_idle;
    logic                 hold_req;
    logic [MV_W-1:0]      cur_open;
    logic [MV_W-1:0]      cur_close;

    lih_in_if  in_ch ();
    lih_out_if out_ch ();

    lid_interlock_hysteresis DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    lid_interlock_hysteresis_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return $urandom_range(0, 2);
        if (roll < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MV_W-1:0] clamp_mv(input int v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return v[MV_W-1:0];
    endfunction

    function automatic logic [MV_W-1:0] pick_mv();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return clamp_mv(int'(cur_open) + $urandom_range(0, 8) - 4);
        if (roll < 6) return clamp_mv(int'(cur_close) + $urandom_range(0, 8) - 4);
        if (roll < 8) return 16'($urandom_range(0, 65535));
        if (roll < 9) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return clamp_mv((int'(cur_open) + int'(cur_close)) / 2);
    endfunction

    // drive the result ready; long holds come from hold_req
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 15) stall_left = gap_len();
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_word(input logic kind, input logic [MV_W-1:0] mv,
                             input logic running);
        t_in_word w;
        int       gap;
        w.kind             = kind;
        w.sample_mv        = mv;
        w.exposure_running = running;
        gap = tx_idle ? gap_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_cfg(input logic [MV_W-1:0] op, input logic [MV_W-1:0] cl,
                           input logic pe);
        drain();
        reg_write(CFG_OPEN_THR, op);
        reg_write(CFG_CLOSE_THR, cl);
        reg_write(CFG_PROT_EN, {15'($urandom_range(0, 32767)), pe});
        cur_open  = op;
        cur_close = cl;
    endtask

    task automatic random_cfg();
        logic [MV_W-1:0] a;
        logic [MV_W-1:0] b;
        logic            pe;
        a  = 16'($urandom_range(0, 65535));
        b  = 16'($urandom_range(0, 65535));
        pe = ($urandom_range(0, 9) < 7);
        case ($urandom_range(0, 5))
            0: set_cfg((a > b) ? a : b, (a > b) ? b : a, pe);
            1: set_cfg((a < b) ? a : b, (a < b) ? b : a, pe);
            2: set_cfg(a, a, pe);
            3: set_cfg(16'hFFFF, 16'h0000, pe);
            4: set_cfg(16'h0000, 16'hFFFF, pe);
            default: set_cfg(a[11:0] + 16'd1500, a[11:0] + 16'd1200, pe);
        endcase
    endtask

    initial begin
        logic running;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_req    = 1'b0;
        cur_open    = OPEN_THR_RST;
        cur_close   = CLOSE_THR_RST;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, protection on
        send_word(KIND_INIT, 16'h0000, 1'b0);
        send_word(KIND_INIT, 16'hFFFF, 1'b1);
        send_word(KIND_PROCESS, 16'd1500, 1'b1);
        send_word(KIND_PROCESS, 16'd2000, 1'b1);
        send_word(KIND_PROCESS, 16'd1500, 1'b1);
        send_word(KIND_PROCESS, 16'd1000, 1'b0);
        send_word(KIND_PROCESS, 16'hFFFF, 1'b0);
        send_word(KIND_PROCESS, 16'h0000, 1'b1);
        send_word(KIND_PROCESS, 16'd2500, 1'b1);

        // protection off releases the pending pause
        set_cfg(16'd2000, 16'd1000, 1'b0);
        send_word(KIND_PROCESS, 16'd1500, 1'b1);
        send_word(KIND_PROCESS, 16'd999, 1'b0);
        send_word(KIND_PROCESS, 16'd2000, 1'b1);

        // inverted polarity
        set_cfg(16'd1000, 16'd2000, 1'b1);
        send_word(KIND_PROCESS, 16'd500, 1'b1);
        send_word(KIND_PROCESS, 16'd1500, 1'b1);
        send_word(KIND_PROCESS, 16'd2000, 1'b0);
        send_word(KIND_INIT, 16'd1000, 1'b0);

        // equal thresholds
        set_cfg(16'd3000, 16'd3000, 1'b1);
        send_word(KIND_PROCESS, 16'd2999, 1'b0);
        send_word(KIND_PROCESS, 16'd3000, 1'b1);
        send_word(KIND_INIT, 16'd3000, 1'b1);

        // extreme thresholds
        set_cfg(16'hFFFF, 16'h0000, 1'b1);
        send_word(KIND_PROCESS, 16'hFFFF, 1'b1);
        send_word(KIND_PROCESS, 16'h0000, 1'b0);
        set_cfg(16'h0000, 16'hFFFF, 1'b0);
        send_word(KIND_PROCESS, 16'h0000, 1'b1);
        send_word(KIND_PROCESS, 16'hFFFF, 1'b0);

        running = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            random_cfg();
            tx_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
            if (ph == 2) begin
                tx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 9) < 2) running = ~running;
                if ($urandom_range(0, 19) == 0) begin
                    send_word(KIND_INIT, pick_mv(), running);
                end else if ($urandom_range(0, 19) == 0) begin
                    send_word(KIND_PROCESS, 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_word(KIND_PROCESS, pick_mv(), running);
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/lih_pkg.sv
sv/lih_if.sv
sv/lih_core.sv
sv/lid_interlock_hysteresis.sv
test/lid_interlock_hysteresis_chk.sv
test/lid_interlock_hysteresis_tb.sv
